[hw/rtl/range_list_to_bitmask_parser_assert.svh]
// assertion macros for the range list parser
`ifndef RANGE_LIST_TO_BITMASK_PARSER_ASSERT_SVH
`define RANGE_LIST_TO_BITMASK_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RLBP_ASSERT_IMPLY(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RLBP_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hw/rtl/rlbp_pkg.sv]
package rlbp_pkg;

    typedef enum logic [1:0] {
        OP_PARSE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_ACCEPTED     = 4'd0,
        ST_DONE         = 4'd1,
        ST_NO_NUMBER    = 4'd2,
        ST_DASH_NO_END  = 4'd3,
        ST_BAD_END      = 4'd4,
        ST_DECREASING   = 4'd5,
        ST_JUNK_RANGE   = 4'd6,
        ST_JUNK_NUMBER  = 4'd7,
        ST_OUT_OF_RANGE = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        PH_FIRST       = 3'd0,
        PH_IN_FIRST    = 3'd1,
        PH_AFTER_FIRST = 3'd2,
        PH_END         = 3'd3,
        PH_IN_END      = 3'd4,
        PH_AFTER_END   = 3'd5,
        PH_STOP        = 3'd6
    } phase_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

endpackage

[hw/rtl/range_list_to_bitmask_parser.sv]
// channel  | handshake            | word
// ---------+----------------------+---------------------------------------
// in       | in_valid / in_stall  | op, char_code, last, word_index
// out      | out_valid / out_stall| status, mask_word
//
// a character that sets no bit is answered straight from idle; a number or range that sets bits runs
// through S_DIV_LO, S_DIV_HI, S_DIV_END, then a read-modify-write of each bitmap word covered
// a word read goes through the registered memory read; a clear writes one memory row per cycle
// after reset a clearing pass runs over every memory row before the first word is taken
// the output register lets a new word in while its result is shown and not stalled; a stalled result
// stalls the input and holds the sequencer before it loads the next one
`include "range_list_to_bitmask_parser_assert.svh"

module range_list_to_bitmask_parser #(
    parameter int MASK_BITS = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  char_code,
    input  logic        last,
    input  logic [3:0]  word_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [63:0] mask_word
);

    localparam int MASK_WORDS = (MASK_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
    localparam int VW         = $clog2(MASK_BITS);
    localparam int ACW        = $clog2(MASK_BITS + 1);
    localparam int AXW        = ACW + 4;
    localparam int OW         = $clog2(WORD_BITS);
    localparam int RW         = VW + 1;
    localparam int PW         = 2 * VW;
    // reciprocal of the word size, quotient comes out exact or one low
    localparam int DIV_MUL    = (1 << VW) / WORD_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_LO,
        S_DIV_HI,
        S_DIV_END,
        S_FILL_RD,
        S_FILL_WR,
        S_DONE
    } seq_t;

    // control state
    seq_t                seq_reg, seq_next;
    rlbp_pkg::phase_t    phase_reg, phase_next;
    logic [ACW-1:0]      acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                dig_reg, dig_next;
    logic [VW-1:0]       rs_reg, rs_next;
    rlbp_pkg::status_t   err_reg, err_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                res_pending_reg, res_pending_next;
    logic                first_reg, first_next;
    logic                out_valid_reg, out_valid_next;
    rlbp_pkg::status_t   status_reg, status_next;
    logic [63:0]         mask_word_reg, mask_word_next;

    // payload
    logic [VW-1:0]       fill_lo_reg, fill_lo_next;
    logic [VW-1:0]       fill_hi_reg, fill_hi_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [AW-1:0]       cur_word_reg, cur_word_next;
    logic [AW-1:0]       end_word_reg, end_word_next;
    logic [OW-1:0]       lo_off_reg, lo_off_next;
    logic [OW-1:0]       hi_off_reg, hi_off_next;
    rlbp_pkg::status_t   res_status_reg, res_status_next;
    logic                res_read_reg, res_read_next;

    // bitmap memory
    logic [WORD_BITS-1:0] mem [MASK_WORDS];
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;

    // parser step
    rlbp_pkg::phase_t    p_phase;
    logic [ACW-1:0]      p_acc;
    logic                p_neg;
    logic                p_dig;
    logic [VW-1:0]       p_rs;
    rlbp_pkg::status_t   p_err;
    rlbp_pkg::status_t   p_close;
    rlbp_pkg::status_t   p_status;
    logic                p_fill;
    logic [VW-1:0]       p_lo;
    logic [VW-1:0]       p_hi;
    logic                p_first_side;
    logic                consumed;
    logic                at_end;

    // word split and fill mask
    logic [VW-1:0]        div_src;
    logic [AW-1:0]        q_est;
    logic [RW-1:0]        rem_est;
    logic [AW-1:0]        q_fix;
    logic [OW-1:0]        off_fix;
    logic [OW-1:0]        lo_bound;
    logic [OW-1:0]        hi_bound;
    logic [WORD_BITS-1:0] fill_mask;

    logic out_free;
    logic accept;
    logic read_in_range;

    function automatic logic [ACW-1:0] add_digit(logic [ACW-1:0] a, logic [7:0] c);
        logic [AXW-1:0] v;
        v = AXW'(a) * AXW'(10) + AXW'(c - rlbp_pkg::CH_ZERO);
        if (v > AXW'(MASK_BITS))
        begin
            return ACW'(MASK_BITS);
        end
        return v[ACW-1:0];
    endfunction

    function automatic rlbp_pkg::status_t close_check(logic [ACW-1:0] a, logic n,
                                                      logic [VW-1:0] r, logic range_end);
        rlbp_pkg::status_t s;
        s = rlbp_pkg::ST_ACCEPTED;
        if (range_end && ((n && a != '0) || a < ACW'(r)))
        begin
            s = rlbp_pkg::ST_DECREASING;
        end
        else if (!range_end && n && a != '0)
        begin
            s = rlbp_pkg::ST_OUT_OF_RANGE;
        end
        else if (a >= ACW'(MASK_BITS))
        begin
            s = rlbp_pkg::ST_OUT_OF_RANGE;
        end
        return s;
    endfunction

    // one character through the parser, including the end of string
    always_comb
    begin
        p_phase      = phase_reg;
        p_acc        = acc_reg;
        p_neg        = neg_reg;
        p_dig        = dig_reg;
        p_rs         = rs_reg;
        p_err        = err_reg;
        p_close      = rlbp_pkg::ST_ACCEPTED;
        p_fill       = 1'b0;
        p_lo         = '0;
        p_hi         = '0;
        consumed     = 1'b0;
        at_end       = (char_code == rlbp_pkg::CH_NUL);

        // a stopped string restarts on the next character, bitmap kept
        if (phase_reg == rlbp_pkg::PH_STOP)
        begin
            p_phase = rlbp_pkg::PH_FIRST;
            p_acc   = '0;
            p_neg   = 1'b0;
            p_dig   = 1'b0;
            p_rs    = '0;
            p_err   = rlbp_pkg::ST_ACCEPTED;
        end
        p_first_side = (p_phase == rlbp_pkg::PH_FIRST) || (p_phase == rlbp_pkg::PH_IN_FIRST);

        if (!at_end)
        begin
            case (p_phase)
                rlbp_pkg::PH_FIRST, rlbp_pkg::PH_END:
                begin
                    consumed = 1'b1;
                    if (!rlbp_pkg::is_blank(char_code))
                    begin
                        if (char_code == rlbp_pkg::CH_PLUS || char_code == rlbp_pkg::CH_DASH ||
                            rlbp_pkg::is_digit(char_code))
                        begin
                            p_acc = '0;
                            p_neg = (char_code == rlbp_pkg::CH_DASH);
                            p_dig = 1'b0;
                            if (rlbp_pkg::is_digit(char_code))
                            begin
                                p_acc = add_digit('0, char_code);
                                p_dig = 1'b1;
                            end
                            p_phase = p_first_side ? rlbp_pkg::PH_IN_FIRST : rlbp_pkg::PH_IN_END;
                        end
                        else
                        begin
                            p_err   = p_first_side ? rlbp_pkg::ST_NO_NUMBER
                                                   : rlbp_pkg::ST_BAD_END;
                            p_phase = rlbp_pkg::PH_STOP;
                        end
                    end
                end
                rlbp_pkg::PH_IN_FIRST, rlbp_pkg::PH_IN_END:
                begin
                    if (rlbp_pkg::is_digit(char_code))
                    begin
                        p_acc    = add_digit(p_acc, char_code);
                        p_dig    = 1'b1;
                        consumed = 1'b1;
                    end
                    else if (!p_dig)
                    begin
                        p_err    = p_first_side ? rlbp_pkg::ST_NO_NUMBER : rlbp_pkg::ST_BAD_END;
                        p_phase  = rlbp_pkg::PH_STOP;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        p_close = close_check(p_acc, p_neg, p_rs, !p_first_side);
                        if (p_close != rlbp_pkg::ST_ACCEPTED)
                        begin
                            p_err    = p_close;
                            p_phase  = rlbp_pkg::PH_STOP;
                            consumed = 1'b1;
                        end
                        else
                        begin
                            // number closed, the character is seen again below
                            p_fill  = 1'b1;
                            p_lo    = p_first_side ? VW'(p_acc) : p_rs;
                            p_hi    = VW'(p_acc);
                            p_rs    = p_first_side ? VW'(p_acc) : p_rs;
                            p_phase = p_first_side ? rlbp_pkg::PH_AFTER_FIRST
                                                   : rlbp_pkg::PH_AFTER_END;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (!consumed)
            begin
                case (p_phase)
                    rlbp_pkg::PH_AFTER_FIRST:
                    begin
                        if (!rlbp_pkg::is_blank(char_code))
                        begin
                            if (char_code == rlbp_pkg::CH_COMMA)
                            begin
                                p_phase = rlbp_pkg::PH_FIRST;
                            end
                            else if (char_code == rlbp_pkg::CH_DASH)
                            begin
                                p_phase = rlbp_pkg::PH_END;
                            end
                            else
                            begin
                                p_err   = rlbp_pkg::ST_JUNK_NUMBER;
                                p_phase = rlbp_pkg::PH_STOP;
                            end
                        end
                    end
                    rlbp_pkg::PH_AFTER_END:
                    begin
                        if (!rlbp_pkg::is_blank(char_code))
                        begin
                            if (char_code == rlbp_pkg::CH_COMMA)
                            begin
                                p_phase = rlbp_pkg::PH_FIRST;
                            end
                            else
                            begin
                                p_err   = rlbp_pkg::ST_JUNK_RANGE;
                                p_phase = rlbp_pkg::PH_STOP;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // end of string
        if (at_end || (last && p_phase != rlbp_pkg::PH_STOP))
        begin
            p_first_side = (p_phase == rlbp_pkg::PH_IN_FIRST);
            case (p_phase)
                rlbp_pkg::PH_FIRST:
                begin
                    p_err   = rlbp_pkg::ST_NO_NUMBER;
                    p_phase = rlbp_pkg::PH_STOP;
                end
                rlbp_pkg::PH_IN_FIRST, rlbp_pkg::PH_IN_END:
                begin
                    if (!p_dig)
                    begin
                        p_err = p_first_side ? rlbp_pkg::ST_NO_NUMBER : rlbp_pkg::ST_BAD_END;
                    end
                    else
                    begin
                        p_close = close_check(p_acc, p_neg, p_rs, !p_first_side);
                        if (p_close != rlbp_pkg::ST_ACCEPTED)
                        begin
                            p_err = p_close;
                        end
                        else
                        begin
                            p_fill = 1'b1;
                            p_lo   = p_first_side ? VW'(p_acc) : p_rs;
                            p_hi   = VW'(p_acc);
                            p_rs   = p_first_side ? VW'(p_acc) : p_rs;
                            p_err  = rlbp_pkg::ST_DONE;
                        end
                    end
                    p_phase = rlbp_pkg::PH_STOP;
                end
                rlbp_pkg::PH_AFTER_FIRST, rlbp_pkg::PH_AFTER_END:
                begin
                    p_err   = rlbp_pkg::ST_DONE;
                    p_phase = rlbp_pkg::PH_STOP;
                end
                rlbp_pkg::PH_END:
                begin
                    p_err   = rlbp_pkg::ST_DASH_NO_END;
                    p_phase = rlbp_pkg::PH_STOP;
                end
                default:
                begin
                end
            endcase
        end

        p_status = (p_phase == rlbp_pkg::PH_STOP) ? p_err : rlbp_pkg::ST_ACCEPTED;
    end

    // bit number to word and offset: reciprocal estimate then one correction
    always_comb
    begin
        div_src = (seq_reg == S_DIV_HI) ? fill_lo_reg : fill_hi_reg;
        q_est   = AW'(prod_reg >> VW);
        rem_est = RW'(div_src) - RW'(q_est * WORD_BITS);
        if (rem_est >= RW'(WORD_BITS))
        begin
            q_fix   = q_est + 1'b1;
            off_fix = OW'(rem_est - RW'(WORD_BITS));
        end
        else
        begin
            q_fix   = q_est;
            off_fix = OW'(rem_est);
        end
    end

    always_comb
    begin
        lo_bound = first_reg ? lo_off_reg : '0;
        hi_bound = (cur_word_reg == end_word_reg) ? hi_off_reg : OW'(WORD_BITS - 1);
        for (int i = 0; i < WORD_BITS; i++)
        begin
            fill_mask[i] = (OW'(i) >= lo_bound) && (OW'(i) <= hi_bound);
        end
    end

    assign out_free      = !out_valid_reg || !out_stall;
    assign in_stall      = (seq_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept        = in_valid && !in_stall;
    assign read_in_range = (32'(word_index) < MASK_WORDS);

    // sequencer
    always_comb
    begin
        seq_next         = seq_reg;
        phase_next       = phase_reg;
        acc_next         = acc_reg;
        neg_next         = neg_reg;
        dig_next         = dig_reg;
        rs_next          = rs_reg;
        err_next         = err_reg;
        clr_cnt_next     = clr_cnt_reg;
        res_pending_next = res_pending_reg;
        first_next       = first_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        mask_word_next   = mask_word_reg;
        fill_lo_next     = fill_lo_reg;
        fill_hi_next     = fill_hi_reg;
        prod_next        = prod_reg;
        cur_word_next    = cur_word_reg;
        end_word_next    = end_word_reg;
        lo_off_next      = lo_off_reg;
        hi_off_next      = hi_off_reg;
        res_status_next  = res_status_reg;
        res_read_next    = res_read_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = cur_word_reg;
        mem_raddr        = cur_word_reg;
        mem_wdata        = mem_rdata | fill_mask;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (seq_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == AW'(MASK_WORDS - 1))
                begin
                    clr_cnt_next = '0;
                    seq_next     = res_pending_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (rlbp_pkg::op_t'(op))
                        rlbp_pkg::OP_PARSE:
                        begin
                            phase_next      = p_phase;
                            acc_next        = p_acc;
                            neg_next        = p_neg;
                            dig_next        = p_dig;
                            rs_next         = p_rs;
                            err_next        = p_err;
                            res_status_next = p_status;
                            res_read_next   = 1'b0;
                            if (p_fill)
                            begin
                                fill_lo_next = p_lo;
                                fill_hi_next = p_hi;
                                seq_next     = S_DIV_LO;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                status_next    = p_status;
                                mask_word_next = '0;
                            end
                        end
                        rlbp_pkg::OP_READ:
                        begin
                            mem_re          = 1'b1;
                            mem_raddr       = AW'(word_index);
                            res_read_next   = read_in_range;
                            res_status_next = rlbp_pkg::ST_ACCEPTED;
                            seq_next        = S_DONE;
                        end
                        rlbp_pkg::OP_CLEAR:
                        begin
                            phase_next       = rlbp_pkg::PH_FIRST;
                            acc_next         = '0;
                            neg_next         = 1'b0;
                            dig_next         = 1'b0;
                            rs_next          = '0;
                            err_next         = rlbp_pkg::ST_ACCEPTED;
                            res_status_next  = rlbp_pkg::ST_ACCEPTED;
                            res_read_next    = 1'b0;
                            res_pending_next = 1'b1;
                            clr_cnt_next     = '0;
                            seq_next         = S_CLEAR;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = rlbp_pkg::ST_ACCEPTED;
                            mask_word_next = '0;
                        end
                    endcase
                end
            end
            S_DIV_LO:
            begin
                prod_next = PW'(fill_lo_reg) * PW'(DIV_MUL);
                seq_next  = S_DIV_HI;
            end
            S_DIV_HI:
            begin
                cur_word_next = q_fix;
                lo_off_next   = off_fix;
                prod_next     = PW'(fill_hi_reg) * PW'(DIV_MUL);
                seq_next      = S_DIV_END;
            end
            S_DIV_END:
            begin
                end_word_next = q_fix;
                hi_off_next   = off_fix;
                first_next    = 1'b1;
                seq_next      = S_FILL_RD;
            end
            S_FILL_RD:
            begin
                mem_re   = 1'b1;
                seq_next = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                mem_we     = 1'b1;
                first_next = 1'b0;
                if (cur_word_reg == end_word_reg)
                begin
                    seq_next = S_DONE;
                end
                else
                begin
                    cur_word_next = cur_word_reg + 1'b1;
                    seq_next      = S_FILL_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    mask_word_next   = res_read_reg ? 64'(mem_rdata) : '0;
                    res_pending_next = 1'b0;
                    seq_next         = S_IDLE;
                end
            end
            default:
            begin
                seq_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= S_CLEAR;
            phase_reg       <= rlbp_pkg::PH_FIRST;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            dig_reg         <= 1'b0;
            rs_reg          <= '0;
            err_reg         <= rlbp_pkg::ST_ACCEPTED;
            clr_cnt_reg     <= '0;
            res_pending_reg <= 1'b0;
            first_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            status_reg      <= rlbp_pkg::ST_ACCEPTED;
            mask_word_reg   <= '0;
        end
        else
        begin
            seq_reg         <= seq_next;
            phase_reg       <= phase_next;
            acc_reg         <= acc_next;
            neg_reg         <= neg_next;
            dig_reg         <= dig_next;
            rs_reg          <= rs_next;
            err_reg         <= err_next;
            clr_cnt_reg     <= clr_cnt_next;
            res_pending_reg <= res_pending_next;
            first_reg       <= first_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            mask_word_reg   <= mask_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_lo_reg    <= fill_lo_next;
        fill_hi_reg    <= fill_hi_next;
        prod_reg       <= prod_next;
        cur_word_reg   <= cur_word_next;
        end_word_reg   <= end_word_next;
        lo_off_reg     <= lo_off_next;
        hi_off_reg     <= hi_off_next;
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
    end

    // bitmap, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign mask_word = mask_word_reg;

    `RLBP_ASSERT_IMPLY(a_fill_order, seq_reg == S_FILL_WR, fill_lo_reg <= fill_hi_reg && cur_word_reg <= end_word_reg, "range fill runs past its last word")
    `RLBP_ASSERT_NEXT(a_fill_ends, seq_reg == S_FILL_WR && cur_word_reg == end_word_reg, seq_reg == S_DONE, "range fill did not finish on its last word")
    `RLBP_ASSERT_IMPLY(a_stop_code, phase_reg == rlbp_pkg::PH_STOP, err_reg != rlbp_pkg::ST_ACCEPTED, "stopped parser holds no final status")

endmodule

[verif/range_list_checker.sv]
module range_list_checker
    import rlbp_pkg::*;
#(
    parameter int MASK_BITS = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  char_code,
    input  logic        last,
    input  logic [3:0]  word_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  status,
    input  logic [63:0] mask_word,
    output int          fail_count,
    output int          outstanding
);

    localparam int MASK_WORDS = (MASK_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int VALUE_BITS = $clog2(MASK_BITS);

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] mask_word;
    } parse_result_t;

    phase_t                  phase;
    logic [15:0]             accum;
    logic                    negative;
    logic                    have_digit;
    logic [VALUE_BITS-1:0]   first_value;
    status_t                 stop_code;
    logic [WORD_BITS-1:0]    bitmap [MASK_WORDS];

    parse_result_t           awaited_results [$];

    function automatic bit blank_char(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void restart_parse();
        phase = PH_FIRST;
        accum = '0;
        negative = 1'b0;
        have_digit = 1'b0;
        first_value = '0;
        stop_code = ST_ACCEPTED;
    endfunction

    function automatic void clear_all();
        restart_parse();
        for (int w = 0; w < MASK_WORDS; w++)
        begin
            bitmap[w] = '0;
        end
    endfunction

    function automatic void halt(status_t code);
        phase = PH_STOP;
        stop_code = code;
    endfunction

    // accumulator saturates at the bitmap size
    function automatic void push_digit(logic [7:0] c);
        int unsigned v;
        v = accum * 10 + (c - CH_ZERO);
        accum = (v > MASK_BITS) ? MASK_BITS : v;
        have_digit = 1'b1;
    endfunction

    function automatic bit start_number(logic [7:0] c, phase_t next_phase);
        accum = '0;
        negative = 1'b0;
        have_digit = 1'b0;
        if (c == CH_PLUS || c == CH_DASH)
        begin
            negative = (c == CH_DASH);
        end
        else if (digit_char(c))
        begin
            push_digit(c);
        end
        else
        begin
            return 1'b0;
        end
        phase = next_phase;
        return 1'b1;
    endfunction

    function automatic bit close_single();
        if ((negative && accum != 0) || accum >= MASK_BITS)
        begin
            halt(ST_OUT_OF_RANGE);
            return 1'b0;
        end
        bitmap[accum / WORD_BITS][accum % WORD_BITS] = 1'b1;
        first_value = accum;
        return 1'b1;
    endfunction

    // decreasing check comes before the size check
    function automatic bit close_range();
        int i;
        if ((negative && accum != 0) || accum < first_value)
        begin
            halt(ST_DECREASING);
            return 1'b0;
        end
        if (accum >= MASK_BITS)
        begin
            halt(ST_OUT_OF_RANGE);
            return 1'b0;
        end
        for (i = first_value; i <= accum; i++)
        begin
            bitmap[i / WORD_BITS][i % WORD_BITS] = 1'b1;
        end
        return 1'b1;
    endfunction

    // a character that closes a number is looked at again in the next phase
    function automatic void take_char(logic [7:0] c);
        bit again;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (phase)
                PH_FIRST:
                begin
                    if (!blank_char(c) && !start_number(c, PH_IN_FIRST))
                        halt(ST_NO_NUMBER);
                end
                PH_IN_FIRST:
                begin
                    if (digit_char(c))
                        push_digit(c);
                    else if (!have_digit)
                        halt(ST_NO_NUMBER);
                    else if (close_single())
                    begin
                        phase = PH_AFTER_FIRST;
                        again = 1'b1;
                    end
                end
                PH_AFTER_FIRST:
                begin
                    if (!blank_char(c))
                    begin
                        if (c == CH_COMMA)
                            phase = PH_FIRST;
                        else if (c == CH_DASH)
                            phase = PH_END;
                        else
                            halt(ST_JUNK_NUMBER);
                    end
                end
                PH_END:
                begin
                    if (!blank_char(c) && !start_number(c, PH_IN_END))
                        halt(ST_BAD_END);
                end
                PH_IN_END:
                begin
                    if (digit_char(c))
                        push_digit(c);
                    else if (!have_digit)
                        halt(ST_BAD_END);
                    else if (close_range())
                    begin
                        phase = PH_AFTER_END;
                        again = 1'b1;
                    end
                end
                PH_AFTER_END:
                begin
                    if (!blank_char(c))
                    begin
                        if (c == CH_COMMA)
                            phase = PH_FIRST;
                        else
                            halt(ST_JUNK_RANGE);
                    end
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    function automatic void end_string();
        case (phase)
            PH_FIRST:
                halt(ST_NO_NUMBER);
            PH_IN_FIRST:
            begin
                if (!have_digit)
                    halt(ST_NO_NUMBER);
                else if (close_single())
                    halt(ST_DONE);
            end
            PH_AFTER_FIRST:
                halt(ST_DONE);
            PH_END:
                halt(ST_DASH_NO_END);
            PH_IN_END:
            begin
                if (!have_digit)
                    halt(ST_BAD_END);
                else if (close_range())
                    halt(ST_DONE);
            end
            PH_AFTER_END:
                halt(ST_DONE);
            default:
            begin
            end
        endcase
    endfunction

    function automatic parse_result_t parse_outcome(logic [1:0] o, logic [7:0] c, logic l,
                                                    logic [3:0] idx);
        parse_result_t r;
        r = '0;
        case (o)
            OP_PARSE:
            begin
                // a stopped string is followed by a fresh one, bitmap kept
                if (phase == PH_STOP)
                    restart_parse();
                if (c == CH_NUL)
                begin
                    end_string();
                end
                else
                begin
                    take_char(c);
                    if (l && phase != PH_STOP)
                        end_string();
                end
                r.status = (phase == PH_STOP) ? stop_code : ST_ACCEPTED;
            end
            OP_READ:
            begin
                if (idx < MASK_WORDS)
                    r.mask_word = bitmap[idx];
            end
            OP_CLEAR:
                clear_all();
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic note_failure(string what, parse_result_t want, parse_result_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: expected status %0d mask %h, got status %0d mask %h",
                     what, want.status, want.mask_word, got.status, got.mask_word);
    endtask

    always @(posedge clk)
    begin
        parse_result_t got;
        parse_result_t want;
        if (!rst_n)
        begin
            clear_all();
            awaited_results.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            // output first: a word taken at this edge cannot already have its result
            if (out_valid && !out_stall)
            begin
                got.status = status;
                got.mask_word = mask_word;
                if (awaited_results.size() == 0)
                begin
                    note_failure("unexpected result", '0, got);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.mask_word !== want.mask_word)
                        note_failure("mismatch", want, got);
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(parse_outcome(op, char_code, last, word_index));
            outstanding = awaited_results.size();
        end
    end

endmodule

[verif/tb.sv]
module tb;
    import rlbp_pkg::*;

    localparam int MASK_BITS    = 1024;
    localparam int WORD_BITS    = 64;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_WORDS = 850;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum {END_BY_LAST, END_BY_NUL, END_NONE} string_end_t;
    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_LONG} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  op = OP_PARSE;
    logic [7:0]  char_code = '0;
    logic        last = 1'b0;
    logic [3:0]  word_index = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [3:0]  status;
    logic [63:0] mask_word;

    int          fail_count;
    int          outstanding;
    int          cycles = 0;
    int          words_sent = 0;
    int          burst_left = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          rx_left = 0;
    logic [7:0]  text [$];

    range_list_to_bitmask_parser #(
        .MASK_BITS (MASK_BITS),
        .WORD_BITS (WORD_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .char_code  (char_code),
        .last       (last),
        .word_index (word_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .mask_word  (mask_word)
    );

    range_list_checker #(
        .MASK_BITS (MASK_BITS),
        .WORD_BITS (WORD_BITS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .char_code   (char_code),
        .last        (last),
        .word_index  (word_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .mask_word   (mask_word),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: free stretches, light and heavy random stalls, long holds
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 120);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
            RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:  out_stall <= ((rx_left % 20) >= 4);
        endcase
    end

    // enters and leaves at a falling edge; valid stays up after the word is taken
    task automatic send_word(logic [1:0] o, logic [7:0] c, logic l, logic [3:0] idx);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        op <= o;
        char_code <= c;
        last <= l;
        word_index <= idx;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    task automatic load_text(string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            text.push_back(s[i]);
        end
    endtask

    task automatic add_blanks();
        int n;
        if ($urandom_range(0, 9) < 3)
        begin
            n = $urandom_range(1, 2);
            repeat (n)
            begin
                if ($urandom_range(0, 1) == 0)
                    text.push_back(CH_SPACE);
                else
                    text.push_back(CH_TAB + $urandom_range(0, 4));
            end
        end
    endtask

    task automatic add_number(int v);
        string digits;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            text.push_back(CH_PLUS);
        else if (pick < 12)
            text.push_back(CH_DASH);
        if ($urandom_range(0, 9) == 0)
            text.push_back(CH_ZERO);
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++)
        begin
            text.push_back(digits[i]);
        end
    endtask

    // a comma list of numbers and ranges, mostly well formed and narrow
    task automatic build_list();
        int n_elems;
        int lo;
        int hi;
        int pick;
        text.delete();
        n_elems = $urandom_range(1, 4);
        for (int e = 0; e < n_elems; e++)
        begin
            if (e > 0)
                text.push_back(CH_COMMA);
            add_blanks();
            pick = $urandom_range(0, 99);
            lo = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, MASK_BITS - 1);
            if (pick < 3)
                lo = $urandom_range(MASK_BITS, 99999);
            add_number(lo);
            add_blanks();
            if (pick >= 40)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    hi = lo + $urandom_range(0, 40);
                else if (pick < 88)
                    hi = lo + $urandom_range(0, 300);
                else if (pick < 90)
                    hi = lo + $urandom_range(0, MASK_BITS - 1);
                else if (pick < 96)
                    hi = (lo > 0) ? lo - $urandom_range(1, lo) : 0;
                else
                    hi = $urandom_range(MASK_BITS, 3000);
                if (pick < 90 && hi > MASK_BITS - 1)
                    hi = MASK_BITS - 1;
                text.push_back(CH_DASH);
                add_blanks();
                add_number(hi);
                add_blanks();
            end
        end
        if ($urandom_range(0, 19) == 0)
            text.push_back(CH_COMMA);
        // occasional stray character anywhere in the string
        if ($urandom_range(0, 15) == 0)
            text[$urandom_range(0, text.size() - 1)] = $urandom_range(1, 255);
    endtask

    task automatic send_text(string_end_t how, bit wild);
        logic l;
        for (int i = 0; i < text.size(); i++)
        begin
            l = (i == text.size() - 1) && (how == END_BY_LAST);
            if (wild && $urandom_range(0, 49) == 0)
                l = 1'b1;
            if (wild && $urandom_range(0, 29) == 0)
                send_word(OP_READ, $urandom, $urandom, $urandom);
            send_word(OP_PARSE, text[i], l, $urandom);
        end
        if (how == END_BY_NUL)
            send_word(OP_PARSE, CH_NUL, $urandom_range(0, 1), $urandom);
    endtask

    initial
    begin
        int pick;
        bit mid_drain_done;
        mid_drain_done = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty string, size limit, full range with minus zero, reads at both ends
        send_word(OP_READ, 8'hFF, 1'b1, 4'd0);
        send_word(OP_PARSE, CH_NUL, 1'b0, 4'hF);
        load_text("1024");
        send_text(END_BY_LAST, 1'b0);
        load_text("-0-1023");
        send_text(END_BY_LAST, 1'b0);
        send_word(OP_READ, 8'h00, 1'b0, 4'd15);
        send_word(OP_READ, 8'hA5, 1'b1, 4'd0);
        send_word(OP_CLEAR, 8'h5A, 1'b1, 4'hA);
        load_text("5-3");
        send_text(END_BY_LAST, 1'b0);
        load_text("7,");
        send_text(END_BY_LAST, 1'b0);
        load_text("+");
        send_text(END_BY_LAST, 1'b0);
        send_word(OP_UNUSED, 8'hFF, 1'b1, 4'hF);
        send_word(OP_READ, 8'h00, 1'b0, 4'd0);

        pause_until_drained();

        while (words_sent < RANDOM_WORDS + 25)
        begin
            if (!mid_drain_done && words_sent > RANDOM_WORDS / 2)
            begin
                pause_until_drained();
                mid_drain_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                build_list();
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    send_text(END_BY_LAST, 1'b1);
                else if (pick < 19)
                    send_text(END_BY_NUL, 1'b1);
                else
                    send_text(END_NONE, 1'b1);
            end
            else if (pick < 83)
                send_word(OP_READ, $urandom, $urandom, $urandom);
            else if (pick < 87)
                send_word(OP_CLEAR, $urandom, $urandom, $urandom);
            else if (pick < 89)
                send_word(OP_UNUSED, $urandom, $urandom, $urandom);
            else
                send_word(OP_PARSE, $urandom_range(0, 255), $urandom_range(0, 1), $urandom);
        end

        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (60) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rlbp_pkg.sv
hw/rtl/range_list_to_bitmask_parser.sv
verif/range_list_checker.sv
verif/tb.sv
